@@ src/sfcg_pkg.sv @@
// Shared types, constants and helpers of the subimage fragment command generator.
`default_nettype none

package sfcg_pkg;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_FRAME_WIDTH   = 2'd0;
   localparam logic [1:0] CSR_SCALE_ONE     = 2'd1;
   localparam logic [1:0] CSR_SHADER_NUMBER = 2'd2;

   localparam logic [10:0] FRAME_WIDTH_RESET   = 11'd396;
   localparam logic        SCALE_ONE_RESET     = 1'b1;
   localparam logic [7:0]  SHADER_NUMBER_RESET = 8'd255;

   // Pixel format codes.
   localparam logic [2:0] FMT_CODE_P4_A = 3'd3;
   localparam logic [2:0] FMT_CODE_P8_A = 3'd4;
   localparam logic [2:0] FMT_CODE_P8_B = 3'd5;
   localparam logic [2:0] FMT_CODE_P4_B = 3'd6;

   // Offset of the pixel data behind the palette of a four-bit image.
   localparam logic [12:0] P4_DATA_BASE = 13'd32;

   localparam int MUL_A_W = 13;
   localparam int MUL_B_W = 12;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   typedef enum logic [1:0] {
      FMT_PAL8,
      FMT_PAL4,
      FMT_RGB16
   } fmt_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SRC,
      ST_DST,
      ST_CMD,
      ST_WAIT
   } state_type;

   typedef struct packed {
      logic               en;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_op_type;

   function automatic fmt_type fmt_decode(input logic [2:0] code);
      fmt_type cls;
      if (code == FMT_CODE_P8_A || code == FMT_CODE_P8_B) begin
         cls = FMT_PAL8;
      end else if (code == FMT_CODE_P4_A || code == FMT_CODE_P4_B) begin
         cls = FMT_PAL4;
      end else begin
         cls = FMT_RGB16;
      end
      return cls;
   endfunction

endpackage

`default_nettype wire

@@ src/sfcg_mul.sv @@
// Shared multiplier of the command generator with a registered product.
`default_nettype none

module sfcg_mul (
   input  wire logic                              clock,
   input  wire sfcg_pkg::mul_op_type              op,
   output logic [sfcg_pkg::PROD_W-1:0]            product
);

   logic [sfcg_pkg::PROD_W-1:0] product_ff;
   logic [sfcg_pkg::PROD_W-1:0] product_in;

   assign product_in = {{sfcg_pkg::MUL_B_W{1'b0}}, op.a} *
                       {{sfcg_pkg::MUL_A_W{1'b0}}, op.b};

   always_ff @(posedge clock) begin
      if (op.en) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

`default_nettype wire

@@ src/subimage_fragment_command_gen_core.sv @@
// Top level of the subimage fragment command generator: sequencer, item state and ports.
// After the request beat, ST_SRC and ST_DST run two multiply steps on the shared
// multiplier for the source base and the fragment-buffer row, then ST_CMD builds
// the first command and ST_WAIT offers it until its beat. Each further command is
// built in ST_CMD and offered in ST_WAIT; the final beat returns the block to idle,
// and a request of height zero leaves it in idle.
// Reset is synchronous: the configuration registers take 396, 1 and 255.
`default_nettype none

module subimage_fragment_command_gen_core (
   input  wire logic               clock,
   input  wire logic               reset,

   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [10:0]        csr_data,

   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [10:0] req_pos_x,
   input  wire logic [9:0]         req_pos_y,
   input  wire logic [2:0]         req_pixel_format,
   input  wire logic [11:0]        req_image_width,
   input  wire logic [7:0]         req_palette_count,
   input  wire logic [11:0]        req_src_left,
   input  wire logic [11:0]        req_src_top,
   input  wire logic [9:0]         req_src_width,
   input  wire logic [7:0]         req_src_height,

   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [7:0]              rsp_shader_out,
   output logic [6:0]              rsp_fragment_index,
   output logic [4:0]              rsp_line_count,
   output logic signed [15:0]      rsp_dest_offset,
   output logic [25:0]             rsp_source_offset,
   output logic [10:0]             rsp_column_count,
   output logic signed [0:0]       rsp_edge_first,
   output logic [10:0]             rsp_edge_last,
   output logic                    rsp_nibble_format,
   output logic                    rsp_last_command
);

   // Configuration registers.
   logic [10:0] frame_width_ff;
   logic        scale_one_ff;
   logic [7:0]  shader_ff;

   sfcg_pkg::state_type state_ff, state_in;

   // Per-request state.
   logic [12:0] stride_ff, stride_in;
   logic [11:0] top_ff, top_in;
   logic [25:0] src_ff, src_in;
   logic [15:0] px_ff, px_in;
   logic [10:0] cols_ff, cols_in;
   logic        e1_ff, e1_in;
   logic [10:0] e2_ff, e2_in;
   logic        nib_ff, nib_in;
   logic [3:0]  yoff_ff, yoff_in;
   logic [6:0]  frag_ff, frag_in;
   logic [7:0]  height_ff, height_in;

   // Command output registers.
   logic [7:0]  o_shader_ff, o_shader_in;
   logic [6:0]  o_frag_ff, o_frag_in;
   logic [4:0]  o_lines_ff, o_lines_in;
   logic [15:0] o_dest_ff, o_dest_in;
   logic [25:0] o_src_ff, o_src_in;
   logic [10:0] o_cols_ff, o_cols_in;
   logic        o_e1_ff, o_e1_in;
   logic [10:0] o_e2_ff, o_e2_in;
   logic        o_nib_ff, o_nib_in;
   logic        o_last_ff, o_last_in;

   sfcg_pkg::mul_op_type            mul_op;
   logic [sfcg_pkg::PROD_W-1:0]     product;

   sfcg_pkg::fmt_type fmt_cls;
   logic        ol;
   logic        orr;
   logic [12:0] left_sum;
   logic [12:0] iw_half;
   logic [4:0]  frag_height;
   logic [4:0]  room;
   logic [4:0]  lines;
   logic        last;
   logic [14:0] dest_prod;
   logic [15:0] dest_sum;
   logic [25:0] src_sum;
   logic        req_beat;
   logic        rsp_beat;

   sfcg_mul u_mul (
      .clock   (clock),
      .op      (mul_op),
      .product (product)
   );

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff <= sfcg_pkg::FRAME_WIDTH_RESET;
         scale_one_ff   <= sfcg_pkg::SCALE_ONE_RESET;
         shader_ff      <= sfcg_pkg::SHADER_NUMBER_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            sfcg_pkg::CSR_FRAME_WIDTH: begin
               frame_width_ff <= csr_data;
            end
            sfcg_pkg::CSR_SCALE_ONE: begin
               scale_one_ff <= csr_data[0];
            end
            sfcg_pkg::CSR_SHADER_NUMBER: begin
               shader_ff <= csr_data[7:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign req_ready = (state_ff == sfcg_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == sfcg_pkg::ST_WAIT);
   assign req_beat  = req_valid && req_ready;
   assign rsp_beat  = rsp_valid && rsp_ready;

   // Request decode, used only on the request beat.
   assign fmt_cls  = sfcg_pkg::fmt_decode(req_pixel_format);
   assign ol       = req_src_left[0];
   assign orr      = req_src_left[0] ^ req_src_width[0];
   assign left_sum = {1'b0, req_src_left} + {4'b0000, req_palette_count, 1'b0} + 13'd2;
   assign iw_half  = ({1'b0, req_image_width} + 13'd1) >> 1;

   // Fragment geometry of the command being built.
   assign frag_height = scale_one_ff ? 5'd8 : 5'd16;
   assign room        = frag_height - {1'b0, yoff_ff};
   assign lines       = (height_ff < {3'b000, room}) ? height_ff[4:0] : room;
   assign last        = (height_ff == {3'b000, lines});

   // Only the first command can start inside a fragment; later ones start on row 0,
   // where the product register no longer holds the row term.
   assign dest_prod = (yoff_ff == 4'd0) ? 15'd0 : product[14:0];
   assign dest_sum  = {1'b0, dest_prod} + px_ff;

   // One adder serves both the base offset and the per-command advance.
   assign src_sum = src_ff + {{(26 - sfcg_pkg::PROD_W){1'b0}}, product};

   always_comb begin
      state_in    = state_ff;
      stride_in   = stride_ff;
      top_in      = top_ff;
      src_in      = src_ff;
      px_in       = px_ff;
      cols_in     = cols_ff;
      e1_in       = e1_ff;
      e2_in       = e2_ff;
      nib_in      = nib_ff;
      yoff_in     = yoff_ff;
      frag_in     = frag_ff;
      height_in   = height_ff;
      o_shader_in = o_shader_ff;
      o_frag_in   = o_frag_ff;
      o_lines_in  = o_lines_ff;
      o_dest_in   = o_dest_ff;
      o_src_in    = o_src_ff;
      o_cols_in   = o_cols_ff;
      o_e1_in     = o_e1_ff;
      o_e2_in     = o_e2_ff;
      o_nib_in    = o_nib_ff;
      o_last_in   = o_last_ff;
      mul_op.en   = 1'b0;
      mul_op.a    = stride_ff;
      mul_op.b    = top_ff;

      unique case (state_ff)
         sfcg_pkg::ST_IDLE: begin
            if (req_beat) begin
               top_in    = req_src_top;
               height_in = req_src_height;
               frag_in   = scale_one_ff ? req_pos_y[9:3] : {1'b0, req_pos_y[9:4]};
               yoff_in   = scale_one_ff ? {1'b0, req_pos_y[2:0]} : req_pos_y[3:0];
               px_in     = {{5{req_pos_x[10]}}, req_pos_x};
               cols_in   = {1'b0, req_src_width};
               e1_in     = 1'b0;
               e2_in     = 11'd0;
               nib_in    = 1'b0;
               unique case (fmt_cls)
                  sfcg_pkg::FMT_PAL8: begin
                     stride_in = {1'b0, req_image_width};
                     src_in    = {13'd0, left_sum};
                  end
                  sfcg_pkg::FMT_PAL4: begin
                     stride_in = iw_half;
                     src_in    = {13'd0, sfcg_pkg::P4_DATA_BASE +
                                  {2'b00, req_src_left[11:1]}};
                     // Widen to whole bytes on both edges.
                     e1_in     = ~ol;
                     e2_in     = {1'b0, req_src_width} + {10'd0, ol};
                     cols_in   = {1'b0, req_src_width} + {10'd0, ol} + {10'd0, orr};
                     px_in     = {{5{req_pos_x[10]}}, req_pos_x} - {15'd0, ol};
                     nib_in    = 1'b1;
                  end
                  default: begin
                     stride_in = {req_image_width, 1'b0};
                     src_in    = {13'd0, req_src_left, 1'b0};
                  end
               endcase
               if (req_src_height != 8'd0) begin
                  state_in = sfcg_pkg::ST_SRC;
               end
            end
         end
         sfcg_pkg::ST_SRC: begin
            mul_op.en = 1'b1;
            mul_op.a  = stride_ff;
            mul_op.b  = top_ff;
            state_in  = sfcg_pkg::ST_DST;
         end
         sfcg_pkg::ST_DST: begin
            src_in    = src_sum;
            mul_op.en = 1'b1;
            mul_op.a  = {2'b00, frame_width_ff};
            mul_op.b  = {8'd0, yoff_ff};
            state_in  = sfcg_pkg::ST_CMD;
         end
         sfcg_pkg::ST_CMD: begin
            o_shader_in = shader_ff;
            o_frag_in   = frag_ff;
            o_lines_in  = lines;
            o_dest_in   = {dest_sum[14:0], 1'b0};
            o_src_in    = src_ff;
            o_cols_in   = cols_ff;
            o_e1_in     = e1_ff;
            o_e2_in     = e2_ff;
            o_nib_in    = nib_ff;
            o_last_in   = last;
            // Source advance for the next fragment, ready by the beat.
            mul_op.en   = 1'b1;
            mul_op.a    = stride_ff;
            mul_op.b    = {7'd0, lines};
            state_in    = sfcg_pkg::ST_WAIT;
         end
         sfcg_pkg::ST_WAIT: begin
            if (rsp_beat) begin
               src_in    = src_sum;
               height_in = height_ff - {3'b000, o_lines_ff};
               yoff_in   = 4'd0;
               frag_in   = frag_ff + 7'd1;
               state_in  = o_last_ff ? sfcg_pkg::ST_IDLE : sfcg_pkg::ST_CMD;
            end
         end
         default: begin
            state_in = sfcg_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sfcg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      stride_ff   <= stride_in;
      top_ff      <= top_in;
      src_ff      <= src_in;
      px_ff       <= px_in;
      cols_ff     <= cols_in;
      e1_ff       <= e1_in;
      e2_ff       <= e2_in;
      nib_ff      <= nib_in;
      yoff_ff     <= yoff_in;
      frag_ff     <= frag_in;
      height_ff   <= height_in;
      o_shader_ff <= o_shader_in;
      o_frag_ff   <= o_frag_in;
      o_lines_ff  <= o_lines_in;
      o_dest_ff   <= o_dest_in;
      o_src_ff    <= o_src_in;
      o_cols_ff   <= o_cols_in;
      o_e1_ff     <= o_e1_in;
      o_e2_ff     <= o_e2_in;
      o_nib_ff    <= o_nib_in;
      o_last_ff   <= o_last_in;
   end

   assign rsp_shader_out     = o_shader_ff;
   assign rsp_fragment_index = o_frag_ff;
   assign rsp_line_count     = o_lines_ff;
   assign rsp_dest_offset    = o_dest_ff;
   assign rsp_source_offset  = o_src_ff;
   assign rsp_column_count   = o_cols_ff;
   assign rsp_edge_first     = o_e1_ff;
   assign rsp_edge_last      = o_e2_ff;
   assign rsp_nibble_format  = o_nib_ff;
   assign rsp_last_command   = o_last_ff;

   // A request is never taken while a command is still offered.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request accepted while a command is pending");

   // The final command returns the block to idle on the next cycle.
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_command) |=> req_ready)
      else $error("block not idle after final command");

   // Every command draws between one and a full fragment of lines.
   a_line_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_line_count != 5'd0 && rsp_line_count <= 5'd16))
      else $error("line count out of range");

   // A request of zero height produces no command.
   a_zero_height: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_src_height == 8'd0) |=> (req_ready && !rsp_valid))
      else $error("zero-height request produced work");

endmodule

`default_nettype wire

@@ bench/subimage_fragment_command_gen_core_test.sv @@
// Self-checking testbench of the subimage fragment command generator core.
`default_nettype none

module subimage_fragment_command_gen_core_test;

   localparam int NUM_DIRECTED    = 14;
   localparam int NUM_PHASES      = 6;
   localparam int ITEMS_PER_PHASE = 58;
   localparam int SETTLE_CYCLES   = 8;
   localparam int DRAIN_CYCLES    = 16;
   localparam int WATCHDOG_LIMIT  = 500;
   localparam int MAX_REPORTS     = 100;

   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam logic [2:0] FMT_CODE_RGB16_LO = 3'd0;
   localparam logic [2:0] FMT_CODE_RGB16_A  = 3'd1;
   localparam logic [2:0] FMT_CODE_RGB16_B  = 3'd2;
   localparam logic [2:0] FMT_CODE_RGB16_HI = 3'd7;

   typedef struct packed {
      logic signed [10:0] pos_x;
      logic [9:0]         pos_y;
      logic [2:0]         pixel_format;
      logic [11:0]        image_width;
      logic [7:0]         palette_count;
      logic [11:0]        src_left;
      logic [11:0]        src_top;
      logic [9:0]         src_width;
      logic [7:0]         src_height;
   } blit_type;

   typedef struct packed {
      logic [7:0]  shader;
      logic [6:0]  frag;
      logic [4:0]  lines;
      logic [15:0] dest;
      logic [25:0] src;
      logic [10:0] cols;
      logic        edge_first;
      logic [10:0] edge_last;
      logic        nib;
      logic        last;
   } cmd_type;

   typedef struct packed {
      blit_type blit;
      logic     typed;
      cmd_type  cmd;
   } row_type;

   localparam cmd_type NO_CMD = '0;

   // Rows with typed commands assume the register values after reset.
   row_type directed_rows [NUM_DIRECTED] = '{
      row_type'{blit_type'{11'sd0, 10'd0, FMT_CODE_RGB16_LO, 12'd1, 8'd0, 12'd0, 12'd0,
                           10'd1, 8'd1},
                1'b1, cmd_type'{8'd255, 7'd0, 5'd1, 16'd0, 26'd0, 11'd1, 1'b0, 11'd0, 1'b0,
                                1'b1}},
      row_type'{blit_type'{-11'sd1024, 10'd1023, sfcg_pkg::FMT_CODE_P8_A, 12'd4095, 8'd255,
                           12'd4095, 12'd4095, 10'd1023, 8'd1},
                1'b1, cmd_type'{8'd255, 7'd127, 5'd1, 16'd3496, 26'd16773632, 11'd1023, 1'b0,
                                11'd0, 1'b0, 1'b1}},
      row_type'{blit_type'{11'sd5, 10'd0, sfcg_pkg::FMT_CODE_P4_A, 12'd3, 8'd0, 12'd1, 12'd0,
                           10'd2, 8'd1},
                1'b1, cmd_type'{8'd255, 7'd0, 5'd1, 16'd8, 26'd32, 11'd4, 1'b0, 11'd3, 1'b1,
                                1'b1}},
      row_type'{blit_type'{11'sd0, 10'd0, sfcg_pkg::FMT_CODE_P4_B, 12'd4, 8'd0, 12'd0, 12'd0,
                           10'd3, 8'd1},
                1'b1, cmd_type'{8'd255, 7'd0, 5'd1, 16'd0, 26'd32, 11'd4, 1'b1, 11'd3, 1'b1,
                                1'b1}},
      row_type'{blit_type'{11'sd17, 10'd40, sfcg_pkg::FMT_CODE_P8_B, 12'd9, 8'd2, 12'd3,
                           12'd4, 10'd5, 8'd0},
                1'b0, NO_CMD},
      row_type'{blit_type'{11'sd100, 10'd5, sfcg_pkg::FMT_CODE_P8_B, 12'd20, 8'd3, 12'd2,
                           12'd1, 10'd10, 8'd30},
                1'b0, NO_CMD},
      row_type'{blit_type'{11'sd0, 10'd0, FMT_CODE_RGB16_HI, 12'd4095, 8'd0, 12'd4095,
                           12'd4095, 10'd1023, 8'd255},
                1'b0, NO_CMD},
      row_type'{blit_type'{11'sd300, 10'd1016, FMT_CODE_RGB16_A, 12'd77, 8'd0, 12'd5, 12'd6,
                           10'd33, 8'd255},
                1'b0, NO_CMD},
      row_type'{blit_type'{11'sd1023, 10'd1023, FMT_CODE_RGB16_B, 12'd2048, 8'd0, 12'd2048,
                           12'd2048, 10'd512, 8'd2},
                1'b0, NO_CMD},
      row_type'{blit_type'{-11'sd1024, 10'd7, sfcg_pkg::FMT_CODE_P4_B, 12'd4095, 8'd0,
                           12'd4095, 12'd100, 10'd1023, 8'd17},
                1'b0, NO_CMD},
      row_type'{blit_type'{11'sd8, 10'd9, sfcg_pkg::FMT_CODE_P4_A, 12'd1, 8'd0, 12'd0, 12'd0,
                           10'd0, 8'd9},
                1'b0, NO_CMD},
      row_type'{blit_type'{-11'sd1, 10'd8, sfcg_pkg::FMT_CODE_P8_A, 12'd0, 8'd255, 12'd7,
                           12'd3, 10'd64, 8'd8},
                1'b0, NO_CMD},
      row_type'{blit_type'{11'sd2, 10'd15, FMT_CODE_RGB16_LO, 12'd0, 8'd0, 12'd0, 12'd0,
                           10'd0, 8'd1},
                1'b0, NO_CMD},
      row_type'{blit_type'{11'sd511, 10'd3, sfcg_pkg::FMT_CODE_P4_A, 12'd4095, 8'd0,
                           12'd4094, 12'd4095, 10'd1, 8'd64},
                1'b0, NO_CMD}
   };

   // Register settings per random phase; the last phase runs without idling.
   int unsigned phase_frame_width [NUM_PHASES] = '{0, 2047, 1024, 1, 700, 396};
   int unsigned phase_scale_one   [NUM_PHASES] = '{0, 1, 0, 1, 0, 1};
   int unsigned phase_shader      [NUM_PHASES] = '{0, 170, 85, 255, 1, 128};
   int unsigned phase_idle_pct    [NUM_PHASES] = '{30, 0, 50, 20, 40, 0};

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [10:0] csr_data  = '0;

   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [10:0] req_pos_x         = '0;
   logic [9:0]         req_pos_y         = '0;
   logic [2:0]         req_pixel_format  = '0;
   logic [11:0]        req_image_width   = '0;
   logic [7:0]         req_palette_count = '0;
   logic [11:0]        req_src_left      = '0;
   logic [11:0]        req_src_top       = '0;
   logic [9:0]         req_src_width     = '0;
   logic [7:0]         req_src_height    = '0;

   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [7:0]         rsp_shader_out;
   logic [6:0]         rsp_fragment_index;
   logic [4:0]         rsp_line_count;
   logic signed [15:0] rsp_dest_offset;
   logic [25:0]        rsp_source_offset;
   logic [10:0]        rsp_column_count;
   logic signed [0:0]  rsp_edge_first;
   logic [10:0]        rsp_edge_last;
   logic               rsp_nibble_format;
   logic               rsp_last_command;

   // Register copies used for prediction.
   logic [10:0] fb_width         = sfcg_pkg::FRAME_WIDTH_RESET;
   logic        eight_line_frags = sfcg_pkg::SCALE_ONE_RESET;
   logic [7:0]  shader_copy      = sfcg_pkg::SHADER_NUMBER_RESET;

   cmd_type     pending_cmds[$];
   int unsigned idle_pct     = 0;
   int unsigned fail_count   = 0;
   int unsigned quiet_cycles = 0;
   int unsigned stall_left   = 0;

   subimage_fragment_command_gen_core DUT (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_pixel_format   (req_pixel_format),
      .req_image_width    (req_image_width),
      .req_palette_count  (req_palette_count),
      .req_src_left       (req_src_left),
      .req_src_top        (req_src_top),
      .req_src_width      (req_src_width),
      .req_src_height     (req_src_height),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_shader_out     (rsp_shader_out),
      .rsp_fragment_index (rsp_fragment_index),
      .rsp_line_count     (rsp_line_count),
      .rsp_dest_offset    (rsp_dest_offset),
      .rsp_source_offset  (rsp_source_offset),
      .rsp_column_count   (rsp_column_count),
      .rsp_edge_first     (rsp_edge_first),
      .rsp_edge_last      (rsp_edge_last),
      .rsp_nibble_format  (rsp_nibble_format),
      .rsp_last_command   (rsp_last_command)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Splits one blit into its fragment commands and queues them in order.
   function automatic void plan_fragment_commands(input blit_type b);
      longint  column, stride, src, cols, frag_h, y, rows_left, room, lines, frag, dest;
      logic    left_pad, right_pad;
      cmd_type c;
      column = {{53{b.pos_x[10]}}, b.pos_x};
      cols = b.src_width;
      c = NO_CMD;
      case (b.pixel_format)
         sfcg_pkg::FMT_CODE_P8_A, sfcg_pkg::FMT_CODE_P8_B: begin
            stride = b.image_width;
            src = 2 * b.palette_count + 2 + b.src_top * stride + b.src_left;
         end
         sfcg_pkg::FMT_CODE_P4_A, sfcg_pkg::FMT_CODE_P4_B: begin
            // Nibble formats widen the span to whole bytes on both sides.
            left_pad  = b.src_left[0];
            right_pad = b.src_left[0] ^ b.src_width[0];
            stride = (b.image_width + 1) >> 1;
            src = 32 + b.src_top * stride + (b.src_left >> 1);
            c.edge_first = ~left_pad;
            c.edge_last = b.src_width + left_pad;
            cols = b.src_width + left_pad + right_pad;
            column = column - left_pad;
            c.nib = 1'b1;
         end
         default: begin
            stride = 2 * b.image_width;
            src = b.src_top * stride + 2 * b.src_left;
         end
      endcase
      frag_h = eight_line_frags ? 8 : 16;
      y = b.pos_y;
      frag = y / frag_h;
      rows_left = b.src_height;
      while (rows_left > 0) begin
         room = frag_h - (y % frag_h);
         lines = (rows_left < room) ? rows_left : room;
         dest = 2 * (fb_width * (y % frag_h) + column);
         rows_left = rows_left - lines;
         c.shader = shader_copy;
         c.frag   = frag[6:0];
         c.lines  = lines[4:0];
         c.dest   = dest[15:0];
         c.src    = src[25:0];
         c.cols   = cols[10:0];
         c.last   = (rows_left == 0);
         pending_cmds.push_back(c);
         y = y + lines;
         frag = frag + 1;
         src = src + stride * lines;
      end
   endfunction

   function automatic blit_type random_blit();
      blit_type    b;
      logic [31:0] r0, r1, r2;
      int unsigned pick;
      r0 = $urandom;
      r1 = $urandom;
      r2 = $urandom;
      b.pos_x         = r0[10:0];
      b.pos_y         = r0[20:11];
      b.pixel_format  = r0[23:21];
      b.palette_count = r0[31:24];
      b.image_width   = r1[11:0];
      b.src_left      = r1[23:12];
      b.src_width     = r1[31:22];
      b.src_top       = r2[11:0];
      // Mostly short blits, some empty ones and a share of tall ones.
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
         r2 = 0;
      end else if (pick < 17) begin
         r2 = $urandom_range(1, 40);
      end else begin
         r2 = $urandom_range(41, 255);
      end
      b.src_height = r2[7:0];
      return b;
   endfunction

   task automatic issue_blit(input blit_type b, input logic typed, input cmd_type typed_cmd);
      if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_pos_x         <= b.pos_x;
      req_pos_y         <= b.pos_y;
      req_pixel_format  <= b.pixel_format;
      req_image_width   <= b.image_width;
      req_palette_count <= b.palette_count;
      req_src_left      <= b.src_left;
      req_src_top       <= b.src_top;
      req_src_width     <= b.src_width;
      req_src_height    <= b.src_height;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (typed) begin
         pending_cmds.push_back(typed_cmd);
      end else begin
         plan_fragment_commands(b);
      end
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [10:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         sfcg_pkg::CSR_FRAME_WIDTH:   fb_width = data;
         sfcg_pkg::CSR_SCALE_ONE:     eight_line_frags = data[0];
         sfcg_pkg::CSR_SHADER_NUMBER: shader_copy = data[7:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input int unsigned phase);
      logic [31:0] r;
      r = $urandom;
      write_csr(sfcg_pkg::CSR_FRAME_WIDTH, phase_frame_width[phase][10:0]);
      // Unused upper data bits must be ignored by the one-bit and eight-bit registers.
      write_csr(sfcg_pkg::CSR_SCALE_ONE, {r[9:0], phase_scale_one[phase][0]});
      write_csr(sfcg_pkg::CSR_SHADER_NUMBER, {r[12:10], phase_shader[phase][7:0]});
      write_csr(CSR_UNUSED, r[23:13]);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle(input int unsigned settle);
      req_valid <= 1'b0;
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want != got) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      end
   endtask

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (!reset && idle_pct != 0 && $urandom_range(1, 100) <= idle_pct / 2) begin
         stall_left = $urandom_range(0, 3);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cmd_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_cmds.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
               $display("%0t: command beat with nothing expected, fragment %0d", $time,
                        rsp_fragment_index);
            end
         end else begin
            want = pending_cmds.pop_front();
            check_field("shader_out", want.shader, rsp_shader_out);
            check_field("fragment_index", want.frag, rsp_fragment_index);
            check_field("line_count", want.lines, rsp_line_count);
            check_field("dest_offset", want.dest, $unsigned(rsp_dest_offset));
            check_field("source_offset", want.src, rsp_source_offset);
            check_field("column_count", want.cols, rsp_column_count);
            check_field("edge_first", want.edge_first, $unsigned(rsp_edge_first));
            check_field("edge_last", want.edge_last, rsp_edge_last);
            check_field("nibble_format", want.nib, rsp_nibble_format);
            check_field("last_command", want.last, rsp_last_command);
         end
      end
   end

   // A stuck handshake ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no beat on any channel for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("** subimage_fragment_command_gen_core: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      idle_pct = 20;
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         issue_blit(directed_rows[i].blit, directed_rows[i].typed, directed_rows[i].cmd);
      end

      for (int unsigned p = 0; p < NUM_PHASES; p++) begin
         wait_idle(SETTLE_CYCLES);
         apply_settings(p);
         idle_pct = phase_idle_pct[p];
         repeat (ITEMS_PER_PHASE) issue_blit(random_blit(), 1'b0, NO_CMD);
      end

      wait_idle(DRAIN_CYCLES);
      if (fail_count == 0) begin
         $display("** subimage_fragment_command_gen_core: PASSED **");
      end else begin
         $display("** subimage_fragment_command_gen_core: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ subimage_fragment_command_gen_core.f @@
src/sfcg_pkg.sv
src/sfcg_mul.sv
src/subimage_fragment_command_gen_core.sv
bench/subimage_fragment_command_gen_core_test.sv
